// ===== src/i2cram_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the I2C register access master.
// No dependencies; the sequencer, result register and top level import this package.
package i2cram_pkg;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] CFG_DEV_ADDR    = 2'd0;
  localparam logic [1:0] CFG_PHASE_TICKS = 2'd1;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd2;

  localparam logic [6:0] DEV_ADDR_RST    = 7'd104;
  localparam logic [7:0] PHASE_TICKS_RST = 8'd5;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  typedef enum logic [3:0] {
    STEP_IDLE,
    STEP_START,
    STEP_DEV_W,
    STEP_ACK_DEV_W,
    STEP_REG,
    STEP_ACK_REG,
    STEP_DATA,
    STEP_ACK_DATA,
    STEP_RSTART,
    STEP_DEV_R,
    STEP_ACK_DEV_R,
    STEP_READ,
    STEP_NACK,
    STEP_STOP
  } step_e;

  typedef struct packed {
    logic [6:0] dev_addr;
    logic [7:0] phase_ticks;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_error;
  } res_t;

endpackage

// ===== src/i2cram_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input items, result items, register writes.
// No dependencies.
interface i2cram_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] reg_addr;
  logic [7:0] write_data;
  logic       sda_in;
  modport source (output valid, kind, reg_addr, write_data, sda_in, input ready);
  modport sink (input valid, kind, reg_addr, write_data, sda_in, output ready);
endinterface

interface i2cram_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_pull_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_error;
  modport source (output valid, scl_level, sda_pull_low, busy_res, done_res, read_byte,
                  ack_error, input ready);
  modport sink (input valid, scl_level, sda_pull_low, busy_res, done_res, read_byte,
                ack_error, output ready);
endinterface

interface i2cram_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/i2cram_seq.sv =====
`timescale 1ns / 1ps
// Bus sequencer: state registers, one-pass next-state logic and line decode.
// Depends on i2cram_pkg.
module i2cram_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [1:0]         kind_i,
  input  logic [7:0]         reg_addr_i,
  input  logic [7:0]         write_data_i,
  input  logic               sda_in_i,
  input  i2cram_pkg::cfg_t   cfg_i,
  output i2cram_pkg::res_t   res_o
);
  import i2cram_pkg::*;

  typedef struct packed {
    step_e      step;
    logic [1:0] qp;
    logic [7:0] pc;
    logic [2:0] bc;
    logic [7:0] sr;
    logic [7:0] apc;
    logic       is_read;
    logic [7:0] reg_addr;
    logic [7:0] wdata;
    logic [7:0] rbyte;
    logic       err;
  } seq_t;

  seq_t       st_q, st_d;
  logic       done_d;
  logic [7:0] len, lim, pc_inc, apc_inc;
  logic       is_ack, is_send;
  step_e      nxt;

  function automatic seq_t enter(seq_t s, step_e n, logic [6:0] dev);
    seq_t r;
    r      = s;
    r.step = n;
    r.qp   = 2'd0;
    r.pc   = 8'd0;
    r.bc   = 3'd0;
    r.apc  = 8'd0;
    case (n)
      STEP_DEV_W: r.sr = {dev, 1'b0};
      STEP_REG:   r.sr = s.reg_addr;
      STEP_DATA:  r.sr = s.wdata;
      STEP_DEV_R: r.sr = {dev, 1'b1};
      STEP_READ:  r.sr = 8'd0;
      default:    r.sr = s.sr;
    endcase
    return r;
  endfunction

  always_comb begin
    st_d    = st_q;
    done_d  = 1'b0;
    len     = (cfg_i.phase_ticks == 8'd0) ? 8'd1 : cfg_i.phase_ticks;
    lim     = (cfg_i.ack_timeout == 8'd0) ? 8'd1 : cfg_i.ack_timeout;
    pc_inc  = st_q.pc + 8'd1;
    apc_inc = st_q.apc + 8'd1;
    is_ack  = st_q.step inside {STEP_ACK_DEV_W, STEP_ACK_REG, STEP_ACK_DATA, STEP_ACK_DEV_R};
    is_send = st_q.step inside {STEP_DEV_W, STEP_REG, STEP_DATA, STEP_DEV_R};
    case (st_q.step)
      STEP_START:     nxt = STEP_DEV_W;
      STEP_DEV_W:     nxt = STEP_ACK_DEV_W;
      STEP_ACK_DEV_W: nxt = STEP_REG;
      STEP_REG:       nxt = STEP_ACK_REG;
      STEP_ACK_REG:   nxt = st_q.is_read ? STEP_RSTART : STEP_DATA;
      STEP_DATA:      nxt = STEP_ACK_DATA;
      STEP_ACK_DATA:  nxt = STEP_STOP;
      STEP_RSTART:    nxt = STEP_DEV_R;
      STEP_DEV_R:     nxt = STEP_ACK_DEV_R;
      STEP_ACK_DEV_R: nxt = STEP_READ;
      STEP_READ:      nxt = STEP_NACK;
      STEP_NACK:      nxt = STEP_STOP;
      default:        nxt = STEP_IDLE;
    endcase
    if (accept_i) begin
      if (st_q.step == STEP_IDLE) begin
        if (kind_i == KIND_WRITE || kind_i == KIND_READ) begin
          st_d.reg_addr = reg_addr_i;
          st_d.wdata    = write_data_i;
          st_d.is_read  = (kind_i == KIND_READ);
          st_d.err      = 1'b0;
          st_d          = enter(st_d, STEP_START, cfg_i.dev_addr);
        end
      end else if (is_ack && st_q.qp == 2'd2) begin
        if (!sda_in_i) begin
          st_d.qp = 2'd3;
          st_d.pc = 8'd0;
        end else begin
          st_d.apc = apc_inc;
          if (apc_inc >= lim) begin
            st_d.err = 1'b1;
            st_d     = enter(st_d, STEP_STOP, cfg_i.dev_addr);
          end
        end
      end else if (pc_inc < len) begin
        st_d.pc = pc_inc;
      end else begin
        st_d.pc = 8'd0;
        if (st_q.step == STEP_READ && st_q.qp == 2'd1) begin
          st_d.sr = {st_q.sr[6:0], sda_in_i};
        end
        if (st_q.qp != 2'd3) begin
          st_d.qp = st_q.qp + 2'd1;
        end else if ((is_send || st_q.step == STEP_READ) && st_q.bc != 3'd7) begin
          st_d.bc = st_q.bc + 3'd1;
          st_d.qp = 2'd0;
          if (st_q.step != STEP_READ) begin
            st_d.sr = {st_q.sr[6:0], 1'b0};
          end
        end else begin
          if (st_q.step == STEP_READ) begin
            st_d.rbyte = st_q.sr;
          end
          if (nxt == STEP_IDLE) begin
            done_d = 1'b1;
          end
          st_d = enter(st_d, nxt, cfg_i.dev_addr);
        end
      end
    end
  end

  always_comb begin
    res_o.scl_level    = 1'b1;
    res_o.sda_pull_low = 1'b0;
    res_o.busy_res     = (st_d.step != STEP_IDLE);
    res_o.done_res     = done_d;
    res_o.read_byte    = st_d.rbyte;
    res_o.ack_error    = st_d.err;
    if (st_d.step != STEP_IDLE) begin
      res_o.scl_level = (st_d.qp == 2'd1 || st_d.qp == 2'd2);
      if (st_d.step == STEP_START || st_d.step == STEP_RSTART) begin
        res_o.sda_pull_low = st_d.qp[1];
      end else if (st_d.step == STEP_STOP) begin
        res_o.scl_level    = (st_d.qp != 2'd0);
        res_o.sda_pull_low = !st_d.qp[1];
      end else if (st_d.step inside {STEP_DEV_W, STEP_REG, STEP_DATA, STEP_DEV_R}) begin
        res_o.sda_pull_low = !st_d.sr[7];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{step: STEP_IDLE, default: '0};
    end else begin
      st_q <= st_d;
    end
  end

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && done_d) |=> (st_q.step == STEP_IDLE))
    else $error("done without return to idle");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.step == STEP_IDLE) |-> (st_q.qp == 2'd0 && st_q.pc == 8'd0 && st_q.apc == 8'd0))
    else $error("idle with live phase state");

  a_poll_in_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.apc != 8'd0) |-> (st_q.step == STEP_ACK_DEV_W || st_q.step == STEP_ACK_REG ||
                            st_q.step == STEP_ACK_DATA || st_q.step == STEP_ACK_DEV_R))
    else $error("ack poll count outside ack slot");

  a_err_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !st_q.err && st_d.err) |=> (st_q.step == STEP_STOP))
    else $error("ack error without stop");

endmodule

// ===== src/i2cram_out.sv =====
`timescale 1ns / 1ps
// Result register between sequencer and output channel.
// Depends on i2cram_pkg and i2cram_out_if.
module i2cram_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  i2cram_pkg::res_t res_i,
  output logic             ready_o,
  i2cram_out_if.source     out_ch
);
  import i2cram_pkg::*;

  logic valid_q;
  res_t res_q;

  assign ready_o = !valid_q || out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_ch.valid        = valid_q;
  assign out_ch.scl_level    = res_q.scl_level;
  assign out_ch.sda_pull_low = res_q.sda_pull_low;
  assign out_ch.busy_res     = res_q.busy_res;
  assign out_ch.done_res     = res_q.done_res;
  assign out_ch.read_byte    = res_q.read_byte;
  assign out_ch.ack_error    = res_q.ack_error;

endmodule

// ===== src/i2c_register_access_master.sv =====
`timescale 1ns / 1ps
// Top level of the I2C register access master: configuration registers,
// sequencer and result register. Depends on i2cram_pkg, i2cram_if, i2cram_seq, i2cram_out.
// Result of an item: on the output channel in the cycle after acceptance. One item per
// cycle while out_ch is ready; the single result register is refilled as it drains.
// Reset: asynchronous, active low; sequencer idle, registers at their defaults.
module i2c_register_access_master (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2cram_in_if.sink     in_ch,
  i2cram_out_if.source  out_ch,
  i2cram_cfg_if.sink    cfg_ch
);
  import i2cram_pkg::*;

  cfg_t cfg_q;
  res_t res;
  logic accept;
  logic ready;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = ready;
  assign accept       = in_ch.valid && ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{dev_addr: DEV_ADDR_RST, phase_ticks: PHASE_TICKS_RST,
                 ack_timeout: ACK_TIMEOUT_RST};
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_DEV_ADDR:    cfg_q.dev_addr    <= cfg_ch.data[6:0];
        CFG_PHASE_TICKS: cfg_q.phase_ticks <= cfg_ch.data;
        CFG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  i2cram_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .kind_i       (in_ch.kind),
    .reg_addr_i   (in_ch.reg_addr),
    .write_data_i (in_ch.write_data),
    .sda_in_i     (in_ch.sda_in),
    .cfg_i        (cfg_q),
    .res_o        (res)
  );

  i2cram_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .res_i   (res),
    .ready_o (ready),
    .out_ch  (out_ch)
  );

endmodule
